/* design/bbsc_pkg.sv */
// package for the block byte statistics classifier
// types, sizing constants, class codes and the log rom builder; no dependencies
`timescale 1ns / 1ps
package bbsc_pkg;

    localparam int BLOCK_BYTES   = 8192;
    localparam int DELTA_CHOICES = 5;
    localparam int CNT_W         = $clog2(BLOCK_BYTES + 1);
    localparam int LOG_ENTRIES   = (BLOCK_BYTES >> 4) + 1;
    localparam int ROM_AW        = $clog2(LOG_ENTRIES);
    localparam int ROM_W         = 19;
    localparam int SUM_W         = CNT_W + 8;
    localparam int FX_W          = CNT_W + ROM_W;
    localparam int CMP_W         = FX_W + 4;
    localparam int LINE_LEN      = 17;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int MIN_SIZE      = 512;

    localparam logic [2:0] CLS_SKIP    = 3'd0;
    localparam logic [2:0] CLS_TEXT    = 3'd1;
    localparam logic [2:0] CLS_EXEC    = 3'd2;
    localparam logic [2:0] CLS_NORMAL  = 3'd3;
    localparam logic [2:0] CLS_DELTA   = 3'd4;
    localparam logic [2:0] CLS_BAD     = 3'd5;
    localparam logic [2:0] CLS_FAST    = 3'd6;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       keep;
    } t_item;

    typedef struct packed {
        logic [2:0]  data_class;
        logic [2:0]  delta_index;
        logic [31:0] entropy;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_ACCUM, ST_PRE0, ST_PRE1, ST_FINISH, ST_CALC1, ST_CALC2, ST_OUT
    } t_state;

    typedef logic [ROM_W-1:0] t_rom [LOG_ENTRIES];

    function automatic int delta_dist(input int d);
        case (d)
            0: return 1;
            1: return 2;
            2: return 3;
            3: return 4;
            default: return 8;
        endcase
    endfunction

    function automatic logic [31:0] log2_q24(input logic [31:0] x);
        logic [31:0] k;
        logic [31:0] frac;
        logic [63:0] y;
        k    = 32'd0;
        frac = 32'd0;
        if (x == 32'd0) return 32'd0;
        for (int i = 0; i < 31; i++) begin
            if ((x >> (k + 32'd1)) != 32'd0) k = k + 32'd1;
        end
        y = ({32'd0, x} << 30) >> k;
        for (int b = 0; b < 24; b++) begin
            y    = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31)) begin
                frac = frac | 32'd1;
                y    = y >> 1;
            end
        end
        return (k << 24) | frac;
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [31:0] x;
        logic [63:0] v;
        for (int i = 0; i < LOG_ENTRIES; i++) begin
            x = (i + 1 < LOG_ENTRIES) ? 32'(16 * i + 8) : 32'(BLOCK_BYTES);
            v = (64'd100 * {32'd0, log2_q24(x)} + 64'd32768) >> 16;
            rom[i] = ROM_W'(v);
        end
        return rom;
    endfunction

endpackage

/* design/bbsc_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bbsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/bbsc_log_rom.sv */
// 100*log2 table, 8 fraction bits, registered read
// depends on bbsc_pkg
`timescale 1ns / 1ps
module bbsc_log_rom (
    input  logic                         i_clk,
    input  logic [bbsc_pkg::ROM_AW-1:0]  i_addr,
    output logic [bbsc_pkg::ROM_W-1:0]   o_data
);
    localparam bbsc_pkg::t_rom LOG_ROM = bbsc_pkg::build_rom();

    logic [bbsc_pkg::ROM_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= LOG_ROM[i_addr];
    end

    assign o_data = r_data;
endmodule

/* design/bbsc_front.sv */
// front end: takes byte requests, marks bytes past the block limit, queues them
// depends on bbsc_pkg
`timescale 1ns / 1ps
module bbsc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_item_valid,
    output bbsc_pkg::t_item       o_item,
    input  logic                  i_pop
);
    bbsc_pkg::t_item                r_mem [bbsc_pkg::FIFO_DEPTH];
    logic [bbsc_pkg::FIFO_AW-1:0]   r_wp, r_rp;
    logic [bbsc_pkg::FIFO_AW:0]     r_cnt;
    logic [bbsc_pkg::CNT_W-1:0]     r_bytes;
    logic                           push, pop, keep;

    assign o_ready      = (r_cnt != (bbsc_pkg::FIFO_AW + 1)'(bbsc_pkg::FIFO_DEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_cnt != '0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_mem[r_rp];
    assign keep         = (r_bytes < bbsc_pkg::CNT_W'(bbsc_pkg::BLOCK_BYTES));

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= '{data: i_data_byte, last: i_last_byte, keep: keep};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_bytes <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
                if (i_last_byte) r_bytes <= '0;
                else if (keep)   r_bytes <= r_bytes + 1'b1;
            end
            if (pop) r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

/* design/bbsc_back.sv */
// back end: histogram and pair statistics, finish sweep, classification
// depends on bbsc_pkg, bbsc_ram, bbsc_log_rom
`timescale 1ns / 1ps
module bbsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  bbsc_pkg::t_item    i_item,
    output logic               o_pop,
    output logic               o_res_valid,
    output bbsc_pkg::t_result  o_res,
    input  logic               i_res_ready
);
    localparam int CW = bbsc_pkg::CMP_W;
    localparam int NW = bbsc_pkg::CNT_W;
    localparam int SW = bbsc_pkg::SUM_W;
    localparam int DC = bbsc_pkg::DELTA_CHOICES;

    bbsc_pkg::t_state r_state, n_state;

    // histogram ram ports
    logic          ram_we;
    logic [7:0]    ram_waddr, ram_raddr;
    logic [NW-1:0] ram_wdata, ram_rdata;
    // log rom
    logic [bbsc_pkg::ROM_AW-1:0] rom_addr;
    logic [bbsc_pkg::ROM_W-1:0]  rom_data;

    logic [NW-1:0] r_size;
    logic [7:0]    r_line [bbsc_pkg::LINE_LEN];
    logic [7:0]    sh_line [bbsc_pkg::LINE_LEN];
    logic [NW-1:0] r_eq  [DC];
    logic [SW-1:0] r_sum [DC];

    // increment pipe
    logic          r_s1_valid;
    logic [7:0]    r_s1_addr;
    logic          r_wr_valid;
    logic [7:0]    r_wr_addr;
    logic [NW-1:0] r_wr_data;
    logic [NW-1:0] inc_val;

    // finish sweep
    logic [8:0]    r_idx;
    logic          r_b_valid, r_c_valid, r_d_valid;
    logic [7:0]    r_b_addr;
    logic [NW-1:0] r_c_f;
    logic [bbsc_pkg::FX_W-1:0] r_prod, r_fx;
    logic [8:0]    r_diff;
    logic [NW-1:0] r_high, r_alpha;
    logic [NW-1:0] r_h_sp, r_h_a, r_h_e, r_h_t, r_h_8b, r_h_00, r_h_e8;

    // classification
    logic          r_short, r_text, r_exe, r_norm, r_bad, r_fast;
    logic [2:0]    r_best;
    logic [NW-1:0] r_min_same, r_eq_best;
    logic [SW-1:0] r_max_sum, r_min_sum;
    bbsc_pkg::t_result r_res;

    logic          take, sweep_done;
    logic [CW-1:0] sz, ent;
    logic [NW-1:0] c_min_same;
    logic [SW-1:0] c_max_sum, c_min_sum;
    logic [2:0]    c_best;
    logic          c_delta;

    bbsc_ram #(.WIDTH(NW), .DEPTH(256)) u_hist (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    bbsc_log_rom u_rom (
        .i_clk (i_clk),
        .i_addr(rom_addr),
        .o_data(rom_data)
    );

    assign take       = (r_state == bbsc_pkg::ST_ACCUM) && i_item_valid;
    assign sweep_done = r_idx[8] && !r_b_valid && !r_c_valid && !r_d_valid;
    assign inc_val    = ((r_wr_valid && (r_wr_addr == r_s1_addr)) ? r_wr_data : ram_rdata)
                        + 1'b1;
    assign sz         = CW'(r_size);
    assign ent        = CW'(r_fx >> 8);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bbsc_pkg::ST_CLEAR:  if (r_idx == 9'd255) n_state = bbsc_pkg::ST_ACCUM;
            bbsc_pkg::ST_ACCUM:  if (take && i_item.last) n_state = bbsc_pkg::ST_PRE0;
            bbsc_pkg::ST_PRE0:   n_state = bbsc_pkg::ST_PRE1;
            bbsc_pkg::ST_PRE1:   n_state = bbsc_pkg::ST_FINISH;
            bbsc_pkg::ST_FINISH: if (sweep_done) n_state = bbsc_pkg::ST_CALC1;
            bbsc_pkg::ST_CALC1:  n_state = bbsc_pkg::ST_CALC2;
            bbsc_pkg::ST_CALC2:  n_state = bbsc_pkg::ST_OUT;
            bbsc_pkg::ST_OUT:    if (i_res_ready) n_state = bbsc_pkg::ST_ACCUM;
            default:             n_state = bbsc_pkg::ST_CLEAR;
        endcase
    end

    // memory ports and handshake outputs
    always_comb begin
        o_pop       = take;
        o_res_valid = (r_state == bbsc_pkg::ST_OUT);
        o_res       = r_res;
        ram_raddr   = i_item.data;
        ram_we      = r_s1_valid;
        ram_waddr   = r_s1_addr;
        ram_wdata   = inc_val;
        rom_addr    = bbsc_pkg::ROM_AW'(ram_rdata >> 4);
        case (r_state)
            bbsc_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[7:0];
                ram_wdata = '0;
            end
            bbsc_pkg::ST_PRE0: rom_addr = bbsc_pkg::ROM_AW'(r_size >> 4);
            bbsc_pkg::ST_FINISH: begin
                ram_raddr = r_idx[7:0];
                ram_we    = r_b_valid;
                ram_waddr = r_b_addr;
                ram_wdata = '0;
            end
            default: ;
        endcase
    end

    // shifted look-ahead line
    always_comb begin
        for (int j = 0; j < bbsc_pkg::LINE_LEN - 1; j++) sh_line[j] = r_line[j + 1];
        sh_line[bbsc_pkg::LINE_LEN - 1] = i_item.data;
    end

    // min, max and best distance over the five pair statistics
    always_comb begin
        c_min_same = r_eq[0];
        c_max_sum  = r_sum[0];
        c_min_sum  = r_sum[0];
        c_best     = 3'd0;
        for (int d = 0; d < DC; d++) begin
            if (r_eq[d] < c_min_same) c_min_same = r_eq[d];
            if (r_sum[d] > c_max_sum) c_max_sum = r_sum[d];
            if (r_sum[d] < c_min_sum) begin
                c_min_sum = r_sum[d];
                c_best    = 3'(d);
            end
        end
    end

    assign c_delta = ((CW'(r_max_sum) > (CW'(r_min_sum) << 2))
                      || (CW'(r_max_sum) > CW'(r_min_sum) + CW'(40) * sz))
                     && (CW'(r_eq_best) > CW'(r_min_same) * CW'(3))
                     && (CW'(r_eq[0]) * CW'(10) < sz * CW'(3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bbsc_pkg::ST_CLEAR;
            r_idx      <= '0;
            r_size     <= '0;
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_d_valid  <= 1'b0;
            for (int j = 0; j < bbsc_pkg::LINE_LEN; j++) r_line[j] <= '0;
            for (int d = 0; d < DC; d++) begin
                r_eq[d]  <= '0;
                r_sum[d] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_wr_valid <= r_s1_valid;
            r_wr_addr  <= r_s1_addr;
            r_wr_data  <= inc_val;
            r_s1_valid <= take && i_item.keep;
            r_s1_addr  <= i_item.data;
            r_b_valid  <= 1'b0;
            r_c_valid  <= r_b_valid;
            r_d_valid  <= r_c_valid;

            case (r_state)
                bbsc_pkg::ST_CLEAR: r_idx <= r_idx + 1'b1;
                bbsc_pkg::ST_ACCUM: begin
                    if (take && i_item.keep) begin
                        r_line <= sh_line;
                        r_size <= r_size + 1'b1;
                        if (r_size >= NW'(16)) begin
                            for (int d = 0; d < DC; d++) begin
                                if (sh_line[0] == sh_line[bbsc_pkg::delta_dist(d)])
                                    r_eq[d] <= r_eq[d] + 1'b1;
                                r_sum[d] <= r_sum[d] + SW'(
                                    (sh_line[0] > sh_line[bbsc_pkg::delta_dist(d)])
                                    ? sh_line[0] - sh_line[bbsc_pkg::delta_dist(d)]
                                    : sh_line[bbsc_pkg::delta_dist(d)] - sh_line[0]);
                            end
                        end
                    end
                end
                bbsc_pkg::ST_PRE0: begin
                    r_idx   <= '0;
                    r_diff  <= '0;
                    r_high  <= '0;
                    r_alpha <= '0;
                end
                bbsc_pkg::ST_PRE1: r_fx <= bbsc_pkg::FX_W'(r_size * rom_data);
                bbsc_pkg::ST_FINISH: begin
                    if (!r_idx[8]) begin
                        r_idx     <= r_idx + 1'b1;
                        r_b_valid <= 1'b1;
                        r_b_addr  <= r_idx[7:0];
                    end
                    // bin value from the ram
                    if (r_b_valid) begin
                        r_c_f <= ram_rdata;
                        if (ram_rdata != '0) r_diff <= r_diff + 1'b1;
                        if (r_b_addr[7]) r_high <= r_high + ram_rdata;
                        if (r_b_addr >= 8'h61 && r_b_addr <= 8'h7a)
                            r_alpha <= r_alpha + ram_rdata;
                        case (r_b_addr)
                            8'h20:   r_h_sp <= ram_rdata;
                            8'h61:   r_h_a  <= ram_rdata;
                            8'h65:   r_h_e  <= ram_rdata;
                            8'h74:   r_h_t  <= ram_rdata;
                            8'h8b:   r_h_8b <= ram_rdata;
                            8'h00:   r_h_00 <= ram_rdata;
                            8'he8:   r_h_e8 <= ram_rdata;
                            default: ;
                        endcase
                    end
                    if (r_c_valid) r_prod <= bbsc_pkg::FX_W'(r_c_f * rom_data);
                    if (r_d_valid) r_fx <= (r_prod <= r_fx) ? r_fx - r_prod : '0;
                end
                bbsc_pkg::ST_CALC1: begin
                    r_short    <= (r_size < NW'(bbsc_pkg::MIN_SIZE));
                    r_text     <= (CW'(r_high) < (sz >> 3))
                                  && (CW'(r_h_sp) > (sz >> 7))
                                  && (CW'(r_h_a) + CW'(r_h_e) + CW'(r_h_t) > (sz >> 4))
                                  && (ent > CW'(300) * sz)
                                  && (CW'(r_alpha) > (sz >> 2));
                    r_exe      <= (CW'(r_h_8b) > (sz >> 8))
                                  && (CW'(r_h_00) > ((sz >> 8) << 1))
                                  && (r_h_e8 > NW'(6));
                    r_norm     <= (ent < CW'(400) * sz) && (r_diff < 9'd200);
                    r_bad      <= (ent > CW'(795) * sz);
                    r_fast     <= (ent > CW'(780) * sz);
                    r_best     <= c_best;
                    r_min_same <= c_min_same;
                    r_max_sum  <= c_max_sum;
                    r_min_sum  <= c_min_sum;
                    r_eq_best  <= r_eq[c_best];
                end
                bbsc_pkg::ST_CALC2: begin
                    r_res.entropy     <= r_short ? 32'd0 : 32'(ent);
                    r_res.delta_index <= 3'd0;
                    if (r_short)     r_res.data_class <= bbsc_pkg::CLS_SKIP;
                    else if (r_text) r_res.data_class <= bbsc_pkg::CLS_TEXT;
                    else if (r_exe)  r_res.data_class <= bbsc_pkg::CLS_EXEC;
                    else if (r_norm) r_res.data_class <= bbsc_pkg::CLS_NORMAL;
                    else if (c_delta) begin
                        r_res.data_class  <= bbsc_pkg::CLS_DELTA;
                        r_res.delta_index <= r_best;
                    end
                    else if (r_bad)  r_res.data_class <= bbsc_pkg::CLS_BAD;
                    else if (r_fast) r_res.data_class <= bbsc_pkg::CLS_FAST;
                    else             r_res.data_class <= bbsc_pkg::CLS_NORMAL;
                end
                bbsc_pkg::ST_OUT: begin
                    if (i_res_ready) begin
                        r_size <= '0;
                        for (int j = 0; j < bbsc_pkg::LINE_LEN; j++) r_line[j] <= '0;
                        for (int d = 0; d < DC; d++) begin
                            r_eq[d]  <= '0;
                            r_sum[d] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* design/block_byte_statistics_classifier_core.sv */
// top level of the block byte statistics classifier
// depends on bbsc_pkg, bbsc_front, bbsc_back
`timescale 1ns / 1ps
// Classifies a block of bytes. Each request carries one byte; the request with
// i_last_byte set closes the block and yields exactly one result (class, delta
// distance index, entropy estimate). Only the first BLOCK_BYTES bytes of a block
// count; later ones are accepted and dropped. While a block streams in, one byte
// is taken per cycle unless the queue is full: a four-entry queue feeds the
// histogram update, a read-modify-write on a 256-entry ram with forwarding for
// repeated bytes. After the last byte, the back end loads the size term, sweeps
// all 256 bins of the histogram ram (one bin a cycle through its single read
// port, clearing each bin behind it), drains the multiply stages and runs the
// classification states CALC1 and CALC2. The queue keeps taking up to four
// bytes of the next block during that time. Right after reset a pass over all
// 256 bins clears the histogram ram before the first byte enters the back end.
module block_byte_statistics_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_data_class,
    output logic [2:0]  o_delta_index,
    output logic [31:0] o_entropy_estimate
);
    // front to back queue
    logic              item_valid, pop;
    bbsc_pkg::t_item   item;
    // back end result and output register
    logic              res_valid, res_ready;
    bbsc_pkg::t_result res;
    logic              r_o_valid;
    bbsc_pkg::t_result r_o_res;

    bbsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_item_valid(item_valid),
        .o_item      (item),
        .i_pop       (pop)
    );

    bbsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(item_valid),
        .i_item      (item),
        .o_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register frees the back end as soon as the result is copied
    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_o_res <= res;
    end

    assign o_valid            = r_o_valid;
    assign o_data_class       = r_o_res.data_class;
    assign o_delta_index      = r_o_res.delta_index;
    assign o_entropy_estimate = r_o_res.entropy;
endmodule
